/* design/rdr_pkg.sv */
`default_nettype none
package rdr_pkg;

    // register stages outside the root and quotient loops
    localparam int unsigned FIXED_STAGES = 8;

    // total register stages from s_tdata to m_tdata for a component width w
    function automatic int unsigned stage_count(input int unsigned w);
        return FIXED_STAGES + 2 * w;
    endfunction

endpackage
`default_nettype wire

/* design/rdr_sqrt.sv */
`default_nettype none
// Floor square root, one result bit per register stage, most significant first.
module rdr_sqrt #(
    parameter int W = 16
) (
    input  wire logic           aclk,
    input  wire logic [W-1:0]   en,
    input  wire logic [2*W-1:0] x,
    output logic      [W-1:0]   root
);
    localparam int XW = 2 * W;
    localparam int TW = 2 * W + 1;

    logic [XW-1:0] rem_reg  [W];
    logic [W-1:0]  root_reg [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        localparam int B = W - 1 - k;
        logic [XW-1:0] rem_in;
        logic [W-1:0]  root_in;
        logic [TW-1:0] trial;
        logic [XW-1:0] rem_next;
        logic [W-1:0]  root_next;

        if (k == 0) begin : g_first
            assign rem_in  = x;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // (q + 2^B)^2 - q^2
        assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));

        always_comb begin
            rem_next  = rem_in;
            root_next = root_in;
            if (TW'(rem_in) >= trial) begin
                rem_next  = rem_in - trial[XW-1:0];
                root_next = root_in | (W'(1) << B);
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root = root_reg[W-1];

endmodule
`default_nettype wire

/* design/rdr_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per register stage. The quotient must fit W bits.
module rdr_div #(
    parameter int W = 16
) (
    input  wire logic           aclk,
    input  wire logic [W-1:0]   en,
    input  wire logic [2*W-1:0] num,
    input  wire logic [W:0]     den,
    output logic      [W-1:0]   quo
);
    localparam int NW = 2 * W;
    localparam int RW = 2 * W + 1;

    logic [NW-1:0] rem_reg [W];
    logic [W:0]    den_reg [W];
    logic [W-1:0]  quo_reg [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        localparam int B = W - 1 - k;
        logic [NW-1:0] rem_in;
        logic [W:0]    den_in;
        logic [W-1:0]  quo_in;
        logic [RW-1:0] trial;
        logic [NW-1:0] rem_next;
        logic [W-1:0]  quo_next;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = RW'(den_in) << B;

        always_comb begin
            rem_next = rem_in;
            quo_next = quo_in;
            if (RW'(rem_in) >= trial) begin
                rem_next = rem_in - trial[NW-1:0];
                quo_next = quo_in | (W'(1) << B);
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[W-1];

endmodule
`default_nettype wire

/* design/rotate_direction_to_reference.sv */
// Rotates direction d so that the z axis maps onto reference r.
// Slave channel: one request per beat carries r and d, six signed components
// of COMPONENT_WIDTH bits with COMPONENT_WIDTH-2 fraction bits.
// Master channel: one result per request, the rotated vector, saturated.
// A reference with zero x and y passes d through, negated when rz < 0.
// Stages from acceptance to m_tvalid: input and square stages, one stage
// per root bit, a numerator stage, one stage per quotient bit of the
// normalizing divide, then five stages of products, rounding and sums.
// Throughput: one request per cycle while s_tready is high.
// Every stage has its own valid bit; a stage loads when it is empty or the
// next one moves, so when m_tready is low the pipe closes up its bubbles
// and keeps taking requests until every stage holds one, then s_tready
// drops. Nothing is lost or repeated across a stall.
// Reset (aresetn low, synchronous) empties the pipe; m_tvalid goes low.
`default_nettype none
module rotate_direction_to_reference #(
    parameter int COMPONENT_WIDTH = 16,
    localparam int S_DATA_W = ((6 * COMPONENT_WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W = ((3 * COMPONENT_WIDTH + 7) / 8) * 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // ref_x, ref_y, ref_z, dir_x, dir_y, dir_z, zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // out_x, out_y, out_z, zero pad
    output logic      [M_DATA_W-1:0] m_tdata
);
    localparam int W  = COMPONENT_WIDTH;
    localparam int F  = W - 2;
    localparam int SW = 2 * W + 4;
    localparam int L  = int'(rdr_pkg::stage_count(W)) - 1;

    localparam int ST_SQ0 = 2;
    localparam int ST_NUM = ST_SQ0 + W;
    localparam int ST_DV0 = ST_NUM + 1;
    localparam int ST_M   = ST_DV0 + W;
    localparam int ST_E1  = ST_M + 1;
    localparam int ST_E2  = ST_E1 + 1;
    localparam int ST_E3  = ST_E2 + 1;

    localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sd1 <<< (W - 1));
    localparam logic [W-1:0]         ONE_Q   = W'(1) << F;

    typedef struct packed {
        logic signed [W-1:0] rx;
        logic signed [W-1:0] ry;
        logic signed [W-1:0] rz;
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        logic signed [W-1:0] dz;
        logic                on_axis;
        logic                neg;
    } side_t;

    function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = v + (SW'(1) << (F - 1));
        return t >>> F;
    endfunction

    function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[W-1:0];
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    // ---------------- pipeline control ----------------
    logic [L:0] valid_reg;
    logic [L:0] valid_next;
    logic [L:0] ready;

    assign ready[L] = !valid_reg[L] || m_tready;
    for (genvar s = 0; s < L; s++) begin : g_ready
        assign ready[s] = !valid_reg[s] || ready[s+1];
    end

    always_comb begin
        valid_next = valid_reg;
        if (ready[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int s = 1; s <= L; s++) begin
            if (ready[s]) begin
                valid_next[s] = valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[L];

    // ---------------- side chain: operands travel with the request ----------------
    side_t side_reg [L];
    side_t side_in;

    always_comb begin
        side_in.rx      = s_tdata[0*W +: W];
        side_in.ry      = s_tdata[1*W +: W];
        side_in.rz      = s_tdata[2*W +: W];
        side_in.dx      = s_tdata[3*W +: W];
        side_in.dy      = s_tdata[4*W +: W];
        side_in.dz      = s_tdata[5*W +: W];
        side_in.on_axis = (side_in.rx == '0) && (side_in.ry == '0);
        side_in.neg     = side_in.rz[W-1];
    end

    always_ff @(posedge aclk) begin
        if (ready[0]) begin
            side_reg[0] <= side_in;
        end
    end

    for (genvar s = 1; s < L; s++) begin : g_side
        always_ff @(posedge aclk) begin
            if (ready[s]) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // ---------------- stage 1: squared xy length ----------------
    logic signed [2*W-1:0] sq_x;
    logic signed [2*W-1:0] sq_y;
    logic [2*W-1:0]        n2_reg;

    assign sq_x = side_reg[0].rx * side_reg[0].rx;
    assign sq_y = side_reg[0].ry * side_reg[0].ry;

    always_ff @(posedge aclk) begin
        if (ready[1]) begin
            n2_reg <= sq_x + sq_y;
        end
    end

    // ---------------- root stages ----------------
    logic [W-1:0] n_sq;

    rdr_sqrt #(.W(W)) u_sqrt (
        .aclk (aclk),
        .en   (ready[ST_SQ0 +: W]),
        .x    (n2_reg),
        .root (n_sq)
    );

    // ---------------- numerators for rounded r/n ----------------
    logic [W-1:0]   mag_x;
    logic [W-1:0]   mag_y;
    logic [2*W-1:0] num_x_reg;
    logic [2*W-1:0] num_y_reg;
    logic [W:0]     den_reg;
    logic [W-1:0]   n_chain_reg [ST_NUM:ST_E2];

    assign mag_x = side_reg[ST_NUM-1].rx[W-1] ? W'(-side_reg[ST_NUM-1].rx)
                                              : W'(side_reg[ST_NUM-1].rx);
    assign mag_y = side_reg[ST_NUM-1].ry[W-1] ? W'(-side_reg[ST_NUM-1].ry)
                                              : W'(side_reg[ST_NUM-1].ry);

    always_ff @(posedge aclk) begin
        if (ready[ST_NUM]) begin
            num_x_reg           <= ((2*W)'(mag_x) << (F + 1)) + (2*W)'(n_sq);
            num_y_reg           <= ((2*W)'(mag_y) << (F + 1)) + (2*W)'(n_sq);
            den_reg             <= {n_sq, 1'b0};
            n_chain_reg[ST_NUM] <= n_sq;
        end
    end

    for (genvar s = ST_NUM + 1; s <= ST_E2; s++) begin : g_nchain
        always_ff @(posedge aclk) begin
            if (ready[s]) begin
                n_chain_reg[s] <= n_chain_reg[s-1];
            end
        end
    end

    // ---------------- divide stages ----------------
    logic [W-1:0] q_x;
    logic [W-1:0] q_y;

    rdr_div #(.W(W)) u_div_x (
        .aclk (aclk),
        .en   (ready[ST_DV0 +: W]),
        .num  (num_x_reg),
        .den  (den_reg),
        .quo  (q_x)
    );

    rdr_div #(.W(W)) u_div_y (
        .aclk (aclk),
        .en   (ready[ST_DV0 +: W]),
        .num  (num_y_reg),
        .den  (den_reg),
        .quo  (q_y)
    );

    // ---------------- unit xy part, clamped and signed ----------------
    logic [W-1:0]        qc_x;
    logic [W-1:0]        qc_y;
    logic signed [W-1:0] mx_reg;
    logic signed [W-1:0] my_reg;

    assign qc_x = (q_x > ONE_Q) ? ONE_Q : q_x;
    assign qc_y = (q_y > ONE_Q) ? ONE_Q : q_y;

    always_ff @(posedge aclk) begin
        if (ready[ST_M]) begin
            mx_reg <= side_reg[ST_M-1].rx[W-1] ? -$signed(qc_x) : $signed(qc_x);
            my_reg <= side_reg[ST_M-1].ry[W-1] ? -$signed(qc_y) : $signed(qc_y);
        end
    end

    // ---------------- E1: first products ----------------
    logic signed [W:0]     rz_m1;
    logic signed [2*W-1:0] m_bx;
    logic signed [2*W-1:0] m_by;
    logic signed [2*W-1:0] m_zx;
    logic signed [2*W-1:0] m_zy;
    logic signed [2*W-1:0] m_dx;
    logic signed [2*W-1:0] m_dy;
    logic signed [2*W:0]   m_dz;
    logic signed [SW-1:0]  p_bx_reg;
    logic signed [SW-1:0]  p_by_reg;
    logic signed [SW-1:0]  p_zx_reg;
    logic signed [SW-1:0]  p_zy_reg;
    logic signed [SW-1:0]  p_dx_reg;
    logic signed [SW-1:0]  p_dy_reg;
    logic signed [SW-1:0]  p_dz_reg;
    logic signed [W-1:0]   mx1_reg;
    logic signed [W-1:0]   my1_reg;

    assign rz_m1 = (W+1)'(side_reg[ST_E1-1].rz) - $signed({1'b0, ONE_Q});
    assign m_bx  = side_reg[ST_E1-1].dx * mx_reg;
    assign m_by  = side_reg[ST_E1-1].dy * my_reg;
    assign m_zx  = side_reg[ST_E1-1].rz * mx_reg;
    assign m_zy  = side_reg[ST_E1-1].rz * my_reg;
    assign m_dx  = side_reg[ST_E1-1].dz * side_reg[ST_E1-1].rx;
    assign m_dy  = side_reg[ST_E1-1].dz * side_reg[ST_E1-1].ry;
    assign m_dz  = side_reg[ST_E1-1].dz * rz_m1;

    always_ff @(posedge aclk) begin
        if (ready[ST_E1]) begin
            p_bx_reg <= SW'(m_bx);
            p_by_reg <= SW'(m_by);
            p_zx_reg <= SW'(m_zx);
            p_zy_reg <= SW'(m_zy);
            p_dx_reg <= SW'(m_dx);
            p_dy_reg <= SW'(m_dy);
            p_dz_reg <= SW'(m_dz);
            mx1_reg  <= mx_reg;
            my1_reg  <= my_reg;
        end
    end

    // ---------------- E2: beta, m' - m, rounded dz terms ----------------
    logic signed [W-1:0]  beta_reg;
    logic signed [SW-1:0] ex_reg;
    logic signed [SW-1:0] ey_reg;
    logic signed [SW-1:0] tx_reg;
    logic signed [SW-1:0] ty_reg;
    logic signed [SW-1:0] tz_reg;

    always_ff @(posedge aclk) begin
        if (ready[ST_E2]) begin
            beta_reg <= sat(rnd(p_bx_reg + p_by_reg));
            ex_reg   <= rnd(p_zx_reg) - SW'(mx1_reg);
            ey_reg   <= rnd(p_zy_reg) - SW'(my1_reg);
            tx_reg   <= rnd(p_dx_reg);
            ty_reg   <= rnd(p_dy_reg);
            tz_reg   <= rnd(p_dz_reg);
        end
    end

    // ---------------- E3: beta products ----------------
    logic signed [W+1:0]   ex_n;
    logic signed [W+1:0]   ey_n;
    logic signed [2*W+1:0] m_bex;
    logic signed [2*W+1:0] m_bey;
    logic signed [2*W:0]   m_bn;
    logic signed [SW-1:0]  bex_reg;
    logic signed [SW-1:0]  bey_reg;
    logic signed [SW-1:0]  bnz_reg;
    logic signed [SW-1:0]  tx2_reg;
    logic signed [SW-1:0]  ty2_reg;
    logic signed [SW-1:0]  tz2_reg;

    assign ex_n  = ex_reg[W+1:0];
    assign ey_n  = ey_reg[W+1:0];
    assign m_bex = beta_reg * ex_n;
    assign m_bey = beta_reg * ey_n;
    assign m_bn  = beta_reg * $signed({1'b0, n_chain_reg[ST_E2]});

    always_ff @(posedge aclk) begin
        if (ready[ST_E3]) begin
            bex_reg <= SW'(m_bex);
            bey_reg <= SW'(m_bey);
            bnz_reg <= -SW'(m_bn);
            tx2_reg <= tx_reg;
            ty2_reg <= ty_reg;
            tz2_reg <= tz_reg;
        end
    end

    // ---------------- output stage ----------------
    logic signed [W-1:0] ox_next;
    logic signed [W-1:0] oy_next;
    logic signed [W-1:0] oz_next;
    logic signed [W-1:0] ox_reg;
    logic signed [W-1:0] oy_reg;
    logic signed [W-1:0] oz_reg;
    side_t               so;

    assign so = side_reg[L-1];

    always_comb begin
        if (so.on_axis && so.neg) begin
            ox_next = sat(-SW'(so.dx));
            oy_next = sat(-SW'(so.dy));
            oz_next = sat(-SW'(so.dz));
        end else if (so.on_axis) begin
            ox_next = so.dx;
            oy_next = so.dy;
            oz_next = so.dz;
        end else begin
            ox_next = sat(SW'(so.dx) + tx2_reg + rnd(bex_reg));
            oy_next = sat(SW'(so.dy) + ty2_reg + rnd(bey_reg));
            oz_next = sat(SW'(so.dz) + tz2_reg + rnd(bnz_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[L]) begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
            oz_reg <= oz_next;
        end
    end

    assign m_tdata = M_DATA_W'({oz_reg, oy_reg, ox_reg});

endmodule
`default_nettype wire

/* design/rdr_checker.sv */
`default_nettype none
module rdr_props #(
    parameter int COMPONENT_WIDTH = 16,
    localparam int M_DATA_W = ((3 * COMPONENT_WIDTH + 7) / 8) * 8
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tvalid,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);
    localparam int DEPTH = int'(rdr_pkg::stage_count(COMPONENT_WIDTH));
    localparam int CW    = $clog2(DEPTH + 2) + 1;

    logic          s_fire;
    logic          m_fire;
    logic [CW-1:0] pending_reg;
    logic [CW-1:0] pending_next;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg;
        if (s_fire && !m_fire) begin
            pending_next = pending_reg + CW'(1);
        end else if (m_fire && !s_fire) begin
            pending_next = pending_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result presented right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != '0)
        else $error("result without a pending request");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= CW'(DEPTH))
        else $error("more requests in flight than pipeline stages");

endmodule

bind rotate_direction_to_reference rdr_props #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
) u_rdr_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
